// File: design/tcs_pkg.sv
package tcs_pkg;

  localparam int COLUMN_MAX   = 511;
  localparam int ROW_MAX      = 511;
  localparam int BLINK_PERIOD = 50;

  localparam int COL_W     = $clog2(COLUMN_MAX + 1);
  localparam int ROW_W     = $clog2(ROW_MAX + 1);
  localparam int BLINK_W   = $clog2(BLINK_PERIOD);
  localparam int FUNC_W    = 3;
  localparam int CHAR_W    = 8;
  localparam int CMD_W     = 3;
  localparam int PX_W      = 13;
  localparam int COLOR_W   = 32;
  localparam int CLIM_W    = 9;
  localparam int RLIM_W    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int STEP_W    = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CELL_X_SHIFT = 3;
  localparam int CELL_Y_SHIFT = 4;
  localparam int MARGIN       = 10;
  localparam int TAB_STOP     = 8;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [CLIM_W-1:0]  CLIM_RESET  = 9'd80;
  localparam logic [RLIM_W-1:0]  RLIM_RESET  = 8'd29;
  localparam logic [COLOR_W-1:0] FORE_RESET  = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] BACK_RESET  = 32'hFF00_0000;
  localparam logic [COLOR_W-1:0] CLEAR_PAPER = 32'hFF00_0000;

  typedef enum logic [FUNC_W-1:0] {
    FN_CHAR  = 3'd0,
    FN_TICK  = 3'd1,
    FN_LEFT  = 3'd2,
    FN_RIGHT = 3'd3,
    FN_UP    = 3'd4,
    FN_DOWN  = 3'd5,
    FN_CLEAR = 3'd6
  } func_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_GLYPH        = 3'd0,
    CMD_DRAW_CURSOR  = 3'd1,
    CMD_ERASE_CURSOR = 3'd2,
    CMD_SCROLL       = 3'd3,
    CMD_CLEAR        = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_LIMIT = 4'd0,
    REG_ROW_LIMIT    = 4'd1,
    REG_FORE_COLOR   = 4'd2,
    REG_BACK_COLOR   = 4'd3
  } reg_e;

  typedef enum logic [3:0] {
    EV_CHAR,
    EV_NEWLINE,
    EV_TAB,
    EV_BACKSPACE,
    EV_TICK,
    EV_LEFT,
    EV_RIGHT,
    EV_UP,
    EV_DOWN,
    EV_CLEAR,
    EV_NONE
  } ev_e;

  typedef enum logic [3:0] {
    OP_ERASE,
    OP_DRAW,
    OP_TAB,
    OP_WRAP,
    OP_SCROLL,
    OP_GLYPH,
    OP_CLEAR,
    OP_BLINK,
    OP_END
  } act_e;

  typedef enum logic [2:0] {
    MV_NONE,
    MV_LEFT,
    MV_RIGHT,
    MV_UP,
    MV_DOWN,
    MV_NEWLINE
  } mv_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_e;

  typedef struct packed {
    ev_e               kind;
    logic [CHAR_W-1:0] chr;
  } ev_t;

  typedef struct packed {
    act_e act;
    mv_e  mv;
  } op_t;

  typedef struct packed {
    cmd_e               command;
    logic [PX_W-1:0]    px;
    logic [PX_W-1:0]    py;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] ink;
    logic [COLOR_W-1:0] paper;
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic last;
  } out_t;

  typedef struct packed {
    logic [CLIM_W-1:0]  column_limit;
    logic [RLIM_W-1:0]  row_limit;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
  } cfg_t;

  // erase the cursor, then move and redraw it
  function automatic op_t move_prog(mv_e mv, logic [STEP_W-1:0] step);
    op_t op;
    op = '{act: OP_END, mv: MV_NONE};
    case (step)
      STEP_W'(0): op.act = OP_ERASE;
      STEP_W'(1): op = '{act: OP_DRAW, mv: mv};
      default:    op.act = OP_END;
    endcase
    return op;
  endfunction

  function automatic op_t prog(ev_e kind, logic [STEP_W-1:0] step);
    op_t op;
    op = '{act: OP_END, mv: MV_NONE};
    case (kind)
      EV_CHAR: begin
        case (step)
          STEP_W'(0): op.act = OP_ERASE;
          STEP_W'(1): op.act = OP_WRAP;
          STEP_W'(2): op.act = OP_SCROLL;
          STEP_W'(3): op.act = OP_GLYPH;
          STEP_W'(4): op.act = OP_ERASE;
          STEP_W'(5): op = '{act: OP_DRAW, mv: MV_RIGHT};
          default:    op.act = OP_END;
        endcase
      end
      EV_BACKSPACE: begin
        case (step)
          STEP_W'(0): op.act = OP_ERASE;
          STEP_W'(1): op = '{act: OP_DRAW, mv: MV_LEFT};
          STEP_W'(2): op.act = OP_ERASE;
          STEP_W'(3): op.act = OP_WRAP;
          STEP_W'(4): op.act = OP_SCROLL;
          STEP_W'(5): op.act = OP_GLYPH;
          STEP_W'(6): op.act = OP_ERASE;
          STEP_W'(7): op = '{act: OP_DRAW, mv: MV_RIGHT};
          STEP_W'(8): op.act = OP_ERASE;
          STEP_W'(9): op = '{act: OP_DRAW, mv: MV_LEFT};
          default:    op.act = OP_END;
        endcase
      end
      EV_TAB: begin
        case (step)
          STEP_W'(0): op.act = OP_ERASE;
          STEP_W'(1): op.act = OP_TAB;
          default:    op.act = OP_END;
        endcase
      end
      EV_NEWLINE: op = move_prog(MV_NEWLINE, step);
      EV_LEFT:    op = move_prog(MV_LEFT, step);
      EV_RIGHT:   op = move_prog(MV_RIGHT, step);
      EV_UP:      op = move_prog(MV_UP, step);
      EV_DOWN:    op = move_prog(MV_DOWN, step);
      EV_TICK:    op.act = (step == STEP_W'(0)) ? OP_BLINK : OP_END;
      EV_CLEAR:   op.act = (step == STEP_W'(0)) ? OP_CLEAR : OP_END;
      default:    op.act = OP_END;
    endcase
    return op;
  endfunction

endpackage

// File: design/tcs_if.sv
interface tcs_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcs_pkg::FUNC_W-1:0]  func;
  logic [tcs_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, func, char_code, input ready);
  modport sink (input valid, func, char_code, output ready);
endinterface

interface tcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcs_pkg::CMD_W-1:0]    command;
  logic [tcs_pkg::PX_W-1:0]     pixel_x;
  logic [tcs_pkg::PX_W-1:0]     pixel_y;
  logic [tcs_pkg::CHAR_W-1:0]   glyph_code;
  logic [tcs_pkg::COLOR_W-1:0]  ink_color;
  logic [tcs_pkg::COLOR_W-1:0]  paper_color;
  logic                         last;

  modport source (output valid, command, pixel_x, pixel_y, glyph_code, ink_color,
                  paper_color, last, input ready);
  modport sink (input valid, command, pixel_x, pixel_y, glyph_code, ink_color,
                paper_color, last, output ready);
endinterface

interface tcs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcs_pkg::CFG_IDX_W-1:0]  index;
  logic [tcs_pkg::COLOR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/text_console_cursor_sequencer.sv
// Text console cursor sequencer.
// in_i takes one event per item (character, blink tick, cursor move, clear);
// out_o gives the run of draw commands it causes, last marking the final one
// of each event. cfg_i writes column_limit, row_limit, fore_color and
// back_color by index; it is always ready. The user must write it only while
// idle; the block does not enforce this. An event is decoded and placed in
// a two-item queue, so the input stays ready while the sequencer works, until
// the queue is full. The sequencer runs one program step per cycle while
// out_o is free: 7 steps for a printable character, 11 for backspace, 3 for
// a move, newline or tab, 2 for a blink tick or clear; from idle it first
// picks up the event. Unused function codes are taken and dropped. The step
// count of the sequencer sets the throughput.
// Each command waits in a hold register until the sequencer knows
// whether it is the last of its event, then moves to the output register.
// When out_o is stalled the sequencer halts on its current step; the queue
// keeps taking events until it is full.
// Reset puts the cursor at column 0, row 0, hidden, clears the blink count
// and loads the register defaults (80, 29, white, opaque black).
module text_console_cursor_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcs_in_if.sink     in_i,
  tcs_out_if.source  out_o,
  tcs_cfg_if.sink    cfg_i
);

  tcs_pkg::cfg_t cfg_q, cfg_d;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  tcs_pkg::ev_t  push_ev, pop_ev;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        tcs_pkg::REG_COLUMN_LIMIT: cfg_d.column_limit = cfg_i.data[tcs_pkg::CLIM_W-1:0];
        tcs_pkg::REG_ROW_LIMIT:    cfg_d.row_limit    = cfg_i.data[tcs_pkg::RLIM_W-1:0];
        tcs_pkg::REG_FORE_COLOR:   cfg_d.fore         = cfg_i.data;
        tcs_pkg::REG_BACK_COLOR:   cfg_d.back         = cfg_i.data;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.column_limit <= tcs_pkg::CLIM_RESET;
      cfg_q.row_limit    <= tcs_pkg::RLIM_RESET;
      cfg_q.fore         <= tcs_pkg::FORE_RESET;
      cfg_q.back         <= tcs_pkg::BACK_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tcs_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ev_o    (push_ev),
    .push_ready_i (push_ready)
  );

  tcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ev_i    (push_ev),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_ev_o     (pop_ev),
    .pop_ready_i  (pop_ready)
  );

  tcs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (pop_valid),
    .q_ev_i    (pop_ev),
    .q_ready_o (pop_ready),
    .out_o     (out_o)
  );

  // a clear command is always alone in its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.command == tcs_pkg::CMD_CLEAR)) |-> out_o.last)
    else $error("clear command not marked last");

  // a scroll is always followed by a glyph of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.command == tcs_pkg::CMD_SCROLL)) |-> !out_o.last)
    else $error("scroll command marked last");

  // glyphs carry the programmed colors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.command == tcs_pkg::CMD_GLYPH)) |->
      ((out_o.ink_color == cfg_q.fore) && (out_o.paper_color == cfg_q.back)))
    else $error("glyph colors differ from registers");

endmodule

// File: design/tcs_front.sv
module tcs_front (
  tcs_in_if.sink         in_i,
  output logic           push_valid_o,
  output tcs_pkg::ev_t   push_ev_o,
  input  logic           push_ready_i
);

  tcs_pkg::ev_t ev;

  always_comb begin
    ev.chr  = in_i.char_code;
    ev.kind = tcs_pkg::EV_NONE;
    case (in_i.func)
      tcs_pkg::FN_CHAR: begin
        case (in_i.char_code)
          tcs_pkg::CH_NEWLINE:   ev.kind = tcs_pkg::EV_NEWLINE;
          tcs_pkg::CH_TAB:       ev.kind = tcs_pkg::EV_TAB;
          tcs_pkg::CH_BACKSPACE: begin
            ev.kind = tcs_pkg::EV_BACKSPACE;
            ev.chr  = tcs_pkg::CH_SPACE;
          end
          default:               ev.kind = tcs_pkg::EV_CHAR;
        endcase
      end
      tcs_pkg::FN_TICK:  ev.kind = tcs_pkg::EV_TICK;
      tcs_pkg::FN_LEFT:  ev.kind = tcs_pkg::EV_LEFT;
      tcs_pkg::FN_RIGHT: ev.kind = tcs_pkg::EV_RIGHT;
      tcs_pkg::FN_UP:    ev.kind = tcs_pkg::EV_UP;
      tcs_pkg::FN_DOWN:  ev.kind = tcs_pkg::EV_DOWN;
      tcs_pkg::FN_CLEAR: ev.kind = tcs_pkg::EV_CLEAR;
      default:           ev.kind = tcs_pkg::EV_NONE;
    endcase
  end

  // unused function codes are taken and dropped here
  assign push_ev_o    = ev;
  assign push_valid_o = in_i.valid && (ev.kind != tcs_pkg::EV_NONE);
  assign in_i.ready   = push_ready_i || (ev.kind == tcs_pkg::EV_NONE);

endmodule

// File: design/tcs_queue.sv
module tcs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  tcs_pkg::ev_t  push_ev_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output tcs_pkg::ev_t  pop_ev_o,
  input  logic          pop_ready_i
);

  tcs_pkg::ev_t                 mem_q [tcs_pkg::QUEUE_DEPTH];
  logic [tcs_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [tcs_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [tcs_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                         push, pop;

  assign push_ready_o = count_q != tcs_pkg::QCNT_W'(tcs_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_ev_o     = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tcs_pkg::QPTR_W'(tcs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == tcs_pkg::QPTR_W'(tcs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_ev_i;
    end
  end

endmodule

// File: design/tcs_back.sv
module tcs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcs_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  input  tcs_pkg::ev_t  q_ev_i,
  output logic          q_ready_o,
  tcs_out_if.source     out_o
);

  localparam int COL_W   = tcs_pkg::COL_W;
  localparam int ROW_W   = tcs_pkg::ROW_W;
  localparam int BLINK_W = tcs_pkg::BLINK_W;
  localparam int PX_W    = tcs_pkg::PX_W;

  function automatic logic [PX_W-1:0] px_of(logic [COL_W-1:0] col);
    return (PX_W'(col) << tcs_pkg::CELL_X_SHIFT) + PX_W'(tcs_pkg::MARGIN);
  endfunction

  function automatic logic [PX_W-1:0] py_of(logic [ROW_W-1:0] row);
    return (PX_W'(row) << tcs_pkg::CELL_Y_SHIFT) + PX_W'(tcs_pkg::MARGIN);
  endfunction

  tcs_pkg::st_e               state_q, state_d;
  tcs_pkg::ev_t               ev_q, ev_d;
  logic [tcs_pkg::STEP_W-1:0] step_q, step_d;
  logic [COL_W-1:0]           col_q, col_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic                       shown_q, shown_d;
  logic [BLINK_W-1:0]         blink_q, blink_d;
  tcs_pkg::cmd_t              hold_q, hold_d;
  logic                       hold_valid_q, hold_valid_d;
  tcs_pkg::out_t              out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  tcs_pkg::op_t               op;
  logic                       out_free, adv, done, load;
  logic                       emit;
  tcs_pkg::cmd_t              ecmd;
  logic [COL_W-1:0]           col_mv, col_tab;
  logic [ROW_W-1:0]           row_mv, row_nl;
  logic [COL_W:0]             tab_sum;
  logic [BLINK_W:0]           blink_inc;
  logic                       col_can_inc, row_can_down, wrap_hit, scroll_hit;

  assign op       = tcs_pkg::prog(ev_q.kind, step_q);
  assign out_free = !out_valid_q || out_o.ready;
  assign adv      = (state_q == tcs_pkg::ST_RUN) && out_free;
  assign done     = adv && (op.act == tcs_pkg::OP_END);
  assign q_ready_o = (state_q == tcs_pkg::ST_IDLE) || done;
  assign load     = q_valid_i && q_ready_o;

  assign col_can_inc  = (32'(col_q) < 32'(cfg_i.column_limit)) &&
                        (32'(col_q) < tcs_pkg::COLUMN_MAX);
  assign row_can_down = (32'(row_q) < 32'(cfg_i.row_limit)) &&
                        (32'(row_q) < tcs_pkg::ROW_MAX);
  assign row_nl       = (32'(row_q) < tcs_pkg::ROW_MAX) ? row_q + 1'b1 : row_q;
  assign wrap_hit     = 32'(col_q) >= 32'(cfg_i.column_limit);
  assign scroll_hit   = 32'(row_q) >= 32'(cfg_i.row_limit);

  assign tab_sum = (COL_W + 1)'(col_q & ~COL_W'(tcs_pkg::TAB_STOP - 1)) +
                   (COL_W + 1)'(tcs_pkg::TAB_STOP);
  assign col_tab = (tab_sum > (COL_W + 1)'(tcs_pkg::COLUMN_MAX)) ?
                   COL_W'(tcs_pkg::COLUMN_MAX) : tab_sum[COL_W-1:0];

  assign blink_inc = (BLINK_W + 1)'(blink_q) + 1'b1;

  always_comb begin
    col_mv = col_q;
    row_mv = row_q;
    case (op.mv)
      tcs_pkg::MV_LEFT:    if (col_q != '0) col_mv = col_q - 1'b1;
      tcs_pkg::MV_RIGHT:   if (col_can_inc) col_mv = col_q + 1'b1;
      tcs_pkg::MV_UP:      if (row_q != '0) row_mv = row_q - 1'b1;
      tcs_pkg::MV_DOWN:    if (row_can_down) row_mv = row_q + 1'b1;
      tcs_pkg::MV_NEWLINE: begin
        col_mv = '0;
        row_mv = row_nl;
      end
      default: begin
        col_mv = col_q;
        row_mv = row_q;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcs_pkg::ST_IDLE: if (q_valid_i) state_d = tcs_pkg::ST_RUN;
      tcs_pkg::ST_RUN:  if (done && !q_valid_i) state_d = tcs_pkg::ST_IDLE;
      default:          state_d = tcs_pkg::ST_IDLE;
    endcase
  end

  // step execution
  always_comb begin
    ev_d         = ev_q;
    step_d       = step_q;
    col_d        = col_q;
    row_d        = row_q;
    shown_d      = shown_q;
    blink_d      = blink_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    emit         = 1'b0;
    ecmd.command = tcs_pkg::CMD_GLYPH;
    ecmd.px      = '0;
    ecmd.py      = '0;
    ecmd.glyph   = '0;
    ecmd.ink     = '0;
    ecmd.paper   = '0;

    if (adv) begin
      step_d = step_q + 1'b1;
      case (op.act)
        tcs_pkg::OP_ERASE: begin
          emit         = shown_q;
          ecmd.command = tcs_pkg::CMD_ERASE_CURSOR;
          ecmd.px      = px_of(col_q);
          ecmd.py      = py_of(row_q);
          ecmd.paper   = cfg_i.back;
          shown_d      = 1'b0;
        end
        tcs_pkg::OP_DRAW: begin
          col_d        = col_mv;
          row_d        = row_mv;
          emit         = !shown_q;
          ecmd.command = tcs_pkg::CMD_DRAW_CURSOR;
          ecmd.px      = px_of(col_mv);
          ecmd.py      = py_of(row_mv);
          ecmd.ink     = cfg_i.fore;
          shown_d      = 1'b1;
        end
        tcs_pkg::OP_TAB: col_d = col_tab;
        tcs_pkg::OP_WRAP: begin
          if (wrap_hit) begin
            col_d        = '0;
            row_d        = row_nl;
            emit         = !shown_q;
            ecmd.command = tcs_pkg::CMD_DRAW_CURSOR;
            ecmd.px      = px_of('0);
            ecmd.py      = py_of(row_nl);
            ecmd.ink     = cfg_i.fore;
            shown_d      = 1'b1;
          end
        end
        tcs_pkg::OP_SCROLL: begin
          if (scroll_hit) begin
            emit         = 1'b1;
            ecmd.command = tcs_pkg::CMD_SCROLL;
            ecmd.paper   = cfg_i.back;
            if (row_q != '0) row_d = row_q - 1'b1;
          end
        end
        tcs_pkg::OP_GLYPH: begin
          emit         = 1'b1;
          ecmd.command = tcs_pkg::CMD_GLYPH;
          ecmd.px      = px_of(col_q);
          ecmd.py      = py_of(row_q);
          ecmd.glyph   = ev_q.chr;
          ecmd.ink     = cfg_i.fore;
          ecmd.paper   = cfg_i.back;
        end
        tcs_pkg::OP_CLEAR: begin
          emit         = 1'b1;
          ecmd.command = tcs_pkg::CMD_CLEAR;
          ecmd.paper   = tcs_pkg::CLEAR_PAPER;
          col_d        = '0;
          row_d        = '0;
        end
        tcs_pkg::OP_BLINK: begin
          if (blink_inc >= (BLINK_W + 1)'(tcs_pkg::BLINK_PERIOD)) begin
            blink_d = '0;
            emit    = 1'b1;
            ecmd.px = px_of(col_q);
            ecmd.py = py_of(row_q);
            shown_d = !shown_q;
            if (shown_q) begin
              ecmd.command = tcs_pkg::CMD_ERASE_CURSOR;
              ecmd.paper   = cfg_i.back;
            end else begin
              ecmd.command = tcs_pkg::CMD_DRAW_CURSOR;
              ecmd.ink     = cfg_i.fore;
            end
          end else begin
            blink_d = blink_inc[BLINK_W-1:0];
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase

      // the newest command waits in hold until we know whether it ends the item
      if (op.act == tcs_pkg::OP_END) begin
        if (hold_valid_q) begin
          out_d        = '{cmd: hold_q, last: 1'b1};
          out_valid_d  = 1'b1;
          hold_valid_d = 1'b0;
        end
      end else if (emit) begin
        if (hold_valid_q) begin
          out_d       = '{cmd: hold_q, last: 1'b0};
          out_valid_d = 1'b1;
        end
        hold_d       = ecmd;
        hold_valid_d = 1'b1;
      end
    end

    if (load) begin
      ev_d   = q_ev_i;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tcs_pkg::ST_IDLE;
      step_q       <= '0;
      col_q        <= '0;
      row_q        <= '0;
      shown_q      <= 1'b0;
      blink_q      <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      col_q        <= col_d;
      row_q        <= row_d;
      shown_q      <= shown_d;
      blink_q      <= blink_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.command     = out_q.cmd.command;
  assign out_o.pixel_x     = out_q.cmd.px;
  assign out_o.pixel_y     = out_q.cmd.py;
  assign out_o.glyph_code  = out_q.cmd.glyph;
  assign out_o.ink_color   = out_q.cmd.ink;
  assign out_o.paper_color = out_q.cmd.paper;
  assign out_o.last        = out_q.last;

endmodule
